FILE: design/cbo_pkg.sv
// cbo_pkg: shared types and constants of the color bucket offset block.
// Used by the channel interfaces, the front and back parts and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbo_pkg;

   // Fixed field widths of the channels
   localparam int COLOR_W  = 8;
   localparam int OFFSET_W = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // One classified word as it waits in the queue
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               in_range;
      logic               last_item;
   } cbo_entry_type;

   // Back part sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_INC,
      BK_ZERO,
      BK_RD,
      BK_OUT
   } back_state_type;

endpackage

`default_nettype wire

FILE: design/cbo_if.sv
// cbo_if: valid/ready channel interfaces for label words and offset words.
// Depends on cbo_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cbo_req_if import cbo_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] color;
   logic               last_item;

   modport source (output valid, output color, output last_item, input ready);
   modport sink   (input valid, input color, input last_item, output ready);
endinterface

interface cbo_rsp_if import cbo_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] offset;
   logic                last_offset;
   logic                error;

   modport source (output valid, output offset, output last_offset, output error,
                   input ready);
   modport sink   (input valid, input offset, input last_offset, input error,
                   output ready);
endinterface

`default_nettype wire

FILE: design/cbo_front.sv
// cbo_front: accepts label words, checks the color range and queues them.
// Depends on cbo_pkg and cbo_req_if.
`timescale 1ns / 1ps
`default_nettype none

module cbo_front import cbo_pkg::*; #(
   parameter int NUM_COLORS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   cbo_req_if.sink      req,
   output cbo_entry_type q_entry,
   output logic         q_valid,
   input  wire logic    q_pop
);

   cbo_entry_type            queue_mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]          fill_ff, fill_in;
   logic                     push;
   logic                     pop;
   cbo_entry_type            new_entry;

   // classify the incoming word
   always_comb begin
      new_entry.color     = req.color;
      new_entry.in_range  = ({1'b0, req.color} < (COLOR_W + 1)'(NUM_COLORS));
      new_entry.last_item = req.last_item;
   end

   assign req.ready = (fill_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_entry   = queue_mem[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

`default_nettype wire

FILE: design/cbo_back.sv
// cbo_back: counts colors in the count store, then scans it and sends offsets.
// Depends on cbo_pkg and cbo_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module cbo_back import cbo_pkg::*; #(
   parameter int NUM_COLORS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cbo_entry_type  q_entry,
   input  wire logic           q_valid,
   output logic                q_pop,
   cbo_rsp_if.source           rsp
);

   localparam int IDX_W = $clog2(NUM_COLORS);

   // count store with per-entry valid bits (entry not valid reads as zero)
   logic [OFFSET_BITS-1:0] count_mem [NUM_COLORS];
   logic [NUM_COLORS-1:0]  valid_ff, valid_in;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [OFFSET_BITS-1:0] mem_wd;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [OFFSET_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic [OFFSET_BITS-1:0] rd_count;

   back_state_type         state_ff, state_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic                   cur_last_ff, cur_last_in;
   logic [IDX_W-1:0]       largest_ff, largest_in;
   logic                   error_ff, error_in;
   logic [OFFSET_BITS-1:0] total_ff, total_in;
   logic                   total_ovf_ff, total_ovf_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [OFFSET_BITS-1:0] run_ff, run_in;
   logic [OFFSET_BITS:0]   sum;
   logic                   slot_free;

   logic                   out_valid_ff, out_valid_in;
   logic [OFFSET_W-1:0]    out_offset_ff, out_offset_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_err_ff, out_err_in;

   assign rd_count  = rd_valid_ff ? rd_data_ff : '0;
   assign sum       = {1'b0, run_ff} + {1'b0, rd_count};
   assign slot_free = !out_valid_ff || rsp.ready;

   assign rsp.valid       = out_valid_ff;
   assign rsp.offset      = out_offset_ff;
   assign rsp.last_offset = out_last_ff;
   assign rsp.error       = out_err_ff;

   // sequencer: count phase, then the offset scan
   always_comb begin
      state_in      = state_ff;
      cur_idx_in    = cur_idx_ff;
      cur_last_in   = cur_last_ff;
      largest_in    = largest_ff;
      error_in      = error_ff;
      total_in      = total_ff;
      total_ovf_in  = total_ovf_ff;
      k_in          = k_ff;
      run_in        = run_ff;
      valid_in      = valid_ff;
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cur_idx_ff;
      mem_we        = 1'b0;
      mem_wa        = cur_idx_ff;
      mem_wd        = rd_count + 1'b1;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_offset_in = out_offset_ff;
      out_last_in   = out_last_ff;
      out_err_in    = out_err_ff;

      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.in_range) begin
                  rd_en       = 1'b1;
                  rd_addr     = q_entry.color[IDX_W-1:0];
                  cur_idx_in  = q_entry.color[IDX_W-1:0];
                  cur_last_in = q_entry.last_item;
                  state_in    = BK_INC;
               end else begin
                  error_in = 1'b1;
                  if (q_entry.last_item) begin
                     state_in = BK_ZERO;
                  end
               end
            end
         end
         BK_INC: begin
            // saturated count drops the increment
            if (rd_count == '1) begin
               error_in = 1'b1;
            end else begin
               mem_we               = 1'b1;
               valid_in[cur_idx_ff] = 1'b1;
               if (total_ff == '1) begin
                  total_ovf_in = 1'b1;
               end else begin
                  total_in = total_ff + 1'b1;
               end
            end
            if (cur_idx_ff > largest_ff) begin
               largest_in = cur_idx_ff;
            end
            state_in = cur_last_ff ? BK_ZERO : BK_IDLE;
         end
         BK_ZERO: begin
            if (slot_free) begin
               out_valid_in  = 1'b1;
               out_offset_in = '0;
               out_last_in   = 1'b0;
               out_err_in    = error_ff || total_ovf_ff;
               run_in        = '0;
               k_in          = '0;
               state_in      = BK_RD;
            end
         end
         BK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (slot_free) begin
               run_in = sum[OFFSET_BITS] ? '1 : sum[OFFSET_BITS-1:0];
               out_valid_in  = 1'b1;
               out_offset_in = OFFSET_W'(32'(run_in));
               out_last_in   = (k_ff == largest_ff);
               out_err_in    = error_ff || total_ovf_ff || sum[OFFSET_BITS];
               if (k_ff == largest_ff) begin
                  // set done: clear the store for the next set
                  valid_in     = '0;
                  largest_in   = '0;
                  error_in     = 1'b0;
                  total_in     = '0;
                  total_ovf_in = 1'b0;
                  state_in     = BK_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = BK_RD;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         largest_ff   <= '0;
         error_ff     <= 1'b0;
         total_ff     <= '0;
         total_ovf_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         largest_ff   <= largest_in;
         error_ff     <= error_in;
         total_ff     <= total_in;
         total_ovf_ff <= total_ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      cur_idx_ff    <= cur_idx_in;
      cur_last_ff   <= cur_last_in;
      k_ff          <= k_in;
      run_ff        <= run_in;
      out_offset_ff <= out_offset_in;
      out_last_ff   <= out_last_in;
      out_err_ff    <= out_err_in;
   end

   // count store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff  <= count_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/color_bucket_offsets_core.sv
// color_bucket_offsets_core: color histogram and exclusive prefix-sum offsets.
// Depends on cbo_pkg, cbo_if, cbo_front and cbo_back.
//
// req carries one color label per word, with last_item set on the final
// label of a set. rsp carries offset words: after the last label the block
// sends largest_color+2 offsets, first 0, then running sums of the color
// counts; the final one has last_offset set and equals the counted total.
// error is set on every offset of a set that held an out-of-range color or
// an overflowing count or sum.
// Flow: the front queues up to 4 words and takes one word per cycle while
// there is room. The back handles an in-range label with a registered
// read of the count store, then a write-back, and only flags an
// out-of-range one. After the last label the zero offset goes out first;
// each further offset needs a store read, then the sum, which goes to the
// output register.
// Reset clears the queue, the count store valid bits, the scan sequencer
// and the output register. When the rsp side stalls, the held offset word
// stays put, the scan waits, and the queue fills until req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module color_bucket_offsets_core import cbo_pkg::*; #(
   parameter int NUM_COLORS  = 32,
   parameter int OFFSET_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   cbo_req_if.sink   req,
   cbo_rsp_if.source rsp
);

   cbo_entry_type q_entry;
   logic          q_valid;
   logic          q_pop;

   cbo_front #(
      .NUM_COLORS (NUM_COLORS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   cbo_back #(
      .NUM_COLORS  (NUM_COLORS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_entry (q_entry),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire

FILE: tb/color_bucket_offsets_core_tb.sv
// Self-checking testbench for color_bucket_offsets_core: label words in, offset words out.
// Depends on cbo_pkg, the cbo_req_if/cbo_rsp_if channels and the core itself.
`timescale 1ns / 1ps

module color_bucket_offsets_core_tb;
   import cbo_pkg::*;

   localparam int          NUM_COLORS  = 32;
   localparam int          OFFSET_BITS = 16;
   localparam int unsigned OFFSET_MAX  = (1 << OFFSET_BITS) - 1;
   localparam int          IDLE_PCT    = 27;
   localparam int          TAIL_CYCLES = 40;

   // One label word waiting to be sent, with its pacing hints
   typedef struct {
      logic [COLOR_W-1:0] color;
      logic               last_item;
      logic               no_gap;
      logic               wait_empty;
   } label_word_type;

   // One offset word as the block should return it
   typedef struct {
      logic [OFFSET_W-1:0] offset;
      logic                last_offset;
      logic                error;
   } offset_word_type;

   logic clock;
   logic reset;

   cbo_req_if req_ch ();
   cbo_rsp_if rsp_ch ();

   color_bucket_offsets_core #(
      .NUM_COLORS  (NUM_COLORS),
      .OFFSET_BITS (OFFSET_BITS)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   label_word_type  labels_pending[$];
   offset_word_type offsets_due[$];

   // Histogram shadow of the block
   logic [OFFSET_BITS-1:0] hist_count [NUM_COLORS];
   logic [4:0]             peak_color;
   logic                   set_fault;

   bit label_taken;
   bit steady;
   int fails;
   int labels_sent;
   int sets_done;
   int sets_flagged;
   int words_checked;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Count one label; on the last of a set, queue the prefix-sum offsets
   task automatic tally_label(input logic [COLOR_W-1:0] color, input logic last_item);
      int unsigned         run;
      int                  n;
      bit                  err;
      logic [OFFSET_W-1:0] sums [NUM_COLORS + 1];
      offset_word_type     w;
      if (color < NUM_COLORS) begin
         if (hist_count[color] == OFFSET_MAX)
            set_fault = 1'b1;
         else
            hist_count[color] = hist_count[color] + 1'b1;
         if (color[4:0] > peak_color)
            peak_color = color[4:0];
      end else begin
         set_fault = 1'b1;
      end
      if (last_item) begin
         err = set_fault;
         n   = peak_color + 2;
         run = 0;
         sums[0] = '0;
         for (int k = 1; k < n; k++) begin
            run += hist_count[k - 1];
            // running sum holds at the top of the offset range
            if (run > OFFSET_MAX) begin
               run = OFFSET_MAX;
               err = 1'b1;
            end
            sums[k] = run[OFFSET_W-1:0];
         end
         for (int k = 0; k < n; k++) begin
            w.offset      = sums[k];
            w.last_offset = (k == n - 1);
            w.error       = err;
            offsets_due.push_back(w);
         end
         sets_done++;
         if (err)
            sets_flagged++;
         foreach (hist_count[i])
            hist_count[i] = '0;
         peak_color = '0;
         set_fault  = 1'b0;
      end
   endtask

   task automatic queue_label(input int color, input bit last_item, input bit no_gap,
                              input bit wait_empty);
      label_word_type w;
      w.color      = color[COLOR_W-1:0];
      w.last_item  = last_item;
      w.no_gap     = no_gap;
      w.wait_empty = wait_empty;
      labels_pending.push_back(w);
   endtask

   // Sample both channels; compare offsets, then feed accepted labels to the shadow
   always @(posedge clock) begin : handshake_monitor
      offset_word_type want;
      label_taken = !reset && req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (offsets_due.size() == 0) begin
            $error("unexpected offset word: offset %0d last_offset %0b error %0b",
                   rsp_ch.offset, rsp_ch.last_offset, rsp_ch.error);
            fails++;
         end else begin
            want = offsets_due.pop_front();
            words_checked++;
            if (rsp_ch.offset !== want.offset) begin
               $error("offset: expected %0d, actual %0d", want.offset, rsp_ch.offset);
               fails++;
            end
            if (rsp_ch.last_offset !== want.last_offset) begin
               $error("last_offset: expected %0b, actual %0b",
                      want.last_offset, rsp_ch.last_offset);
               fails++;
            end
            if (rsp_ch.error !== want.error) begin
               $error("error: expected %0b, actual %0b", want.error, rsp_ch.error);
               fails++;
            end
         end
      end
      if (label_taken) begin
         labels_sent++;
         tally_label(req_ch.color, req_ch.last_item);
      end
   end

   // Label driver: holds a word until taken, then maybe idles, then loads the next
   always @(negedge clock) begin : label_driver
      label_word_type w;
      bit             go;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || label_taken) begin
         go = 1'b0;
         if (labels_pending.size() > 0) begin
            if (labels_pending[0].wait_empty && offsets_due.size() > 0)
               go = 1'b0;
            else if (!steady && $urandom_range(99) < IDLE_PCT)
               go = 1'b0;
            else
               go = 1'b1;
         end
         if (go) begin
            w = labels_pending.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.color     <= w.color;
            req_ch.last_item <= w.last_item;
            steady           <= w.no_gap;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Offset sink: random stalls except during the steady stretch
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int len;
      int top;
      int c;
      bit drain;
      int set_idx;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.color     = '0;
      req_ch.last_item = 1'b0;
      rsp_ch.ready     = 1'b0;
      foreach (hist_count[i])
         hist_count[i] = '0;
      peak_color = '0;
      set_fault  = 1'b0;

      // Directed sets: smallest and largest color, out-of-range only, mixed sets
      queue_label(0, 1, 0, 0);
      queue_label(31, 1, 0, 0);
      queue_label(32, 1, 0, 0);
      queue_label(255, 1, 0, 0);
      queue_label(3, 0, 0, 0);
      queue_label(3, 0, 0, 0);
      queue_label(7, 0, 0, 0);
      queue_label(0, 1, 0, 0);
      queue_label(200, 0, 0, 1);
      queue_label(5, 1, 0, 0);
      queue_label(1, 0, 0, 0);
      queue_label(2, 0, 0, 0);
      queue_label(1, 1, 0, 0);
      queue_label(170, 0, 0, 0);
      queue_label(85, 0, 0, 0);
      queue_label(16, 0, 0, 0);
      queue_label(31, 0, 0, 0);
      queue_label(0, 1, 0, 0);
      queue_label(128, 0, 0, 1);
      queue_label(64, 0, 0, 0);
      queue_label(33, 1, 0, 0);
      queue_label(30, 0, 0, 0);
      queue_label(30, 0, 0, 0);
      queue_label(29, 1, 0, 0);

      // Random sets; a stretch of them runs with no idling on either side
      set_idx = 0;
      while (labels_pending.size() < 400) begin
         len   = $urandom_range(1, 12);
         top   = ($urandom_range(3) == 0) ? NUM_COLORS - 1 : $urandom_range(1, NUM_COLORS - 1);
         drain = (set_idx % 9 == 4);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 15)
               c = $urandom_range(255);
            else
               c = $urandom_range(top);
            queue_label(c, i == len - 1,
                        labels_pending.size() >= 150 && labels_pending.size() < 260,
                        drain && i == 0);
         end
         set_idx++;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (labels_pending.size() > 0 || req_ch.valid)
         @(posedge clock);
      while (offsets_due.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d labels in %0d sets, %0d of them flagged in error",
               labels_sent, sets_done, sets_flagged);
      $display("checked %0d offset words over directed and random sets, with stalls",
               words_checked);
      if (fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: files.f
design/cbo_pkg.sv
design/cbo_if.sv
design/cbo_front.sv
design/cbo_back.sv
design/color_bucket_offsets_core.sv
tb/color_bucket_offsets_core_tb.sv
